// File: hdl/cna_pkg.sv
// Package: shared widths, datapath struct and arctangent constants for the CORDIC core.
package cna_pkg;

  localparam int XW = 18;            // CORDIC x/y datapath width
  localparam int AW = 17;            // angle accumulator width
  localparam int MAX_STEPS = 14;     // entries in the arctangent table
  localparam int SHW = 4;            // normalization shift amount width

  localparam logic [15:0] HALF_TURN = 16'h8000;
  localparam logic [15:0] ZERO_ANGLE = 16'h0000;

  // atan(2^-i), 65536 per turn
  localparam logic [15:0] ATAN_STEP [0:MAX_STEPS-1] = '{
    16'h2000, 16'h12e4, 16'h09fb, 16'h0511, 16'h028b, 16'h0146, 16'h00a3,
    16'h0051, 16'h0029, 16'h0014, 16'h000a, 16'h0005, 16'h0003, 16'h0001
  };

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [AW-1:0] acc;
    logic                 neg;    // real part was mirrored
    logic                 four;   // four-quadrant mode
    logic                 zero;   // both parts zero
  } cna_vec_t;

endpackage

// File: hdl/cna_if.sv
// Interfaces: input and result channels of the CORDIC core.
interface cna_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] real_part;
  logic signed [15:0] imag_part;
  logic               four_quadrant;

  modport source(output valid, real_part, imag_part, four_quadrant, input ready);
  modport sink(input valid, real_part, imag_part, four_quadrant, output ready);
endinterface

interface cna_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angle;

  modport source(output valid, angle, input ready);
  modport sink(input valid, angle, output ready);
endinterface

// File: hdl/cna_norm.sv
// Normalization: leading-sign count, shared shift, scale-down and left-plane mirror.
module cna_norm (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic signed [15:0]  real_part,
  input  logic signed [15:0]  imag_part,
  input  logic                four_quadrant,
  output logic                out_valid,
  input  logic                out_ready,
  output cna_pkg::cna_vec_t   out_data
);

  // stage 1: shift amount
  logic                        s1_valid;
  logic signed [15:0]          s1_re;
  logic signed [15:0]          s1_im;
  logic [cna_pkg::SHW-1:0]     s1_shamt;
  logic                        s1_four;
  logic                        s1_zero;
  logic                        s1_ready;
  logic                        s2_ready;

  logic [15:0]                 diff;
  logic [cna_pkg::SHW-1:0]     shamt_next;

  // a set bit marks where a bit differs from its lower neighbor
  assign diff = (real_part ^ {real_part[14:0], 1'b0}) | (imag_part ^ {imag_part[14:0], 1'b0});

  always_comb begin
    shamt_next = '0;
    for (int i = 0; i < 16; i++) begin
      if (diff[i]) shamt_next = cna_pkg::SHW'(15 - i);
    end
  end

  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready) begin
      s1_re    <= real_part;
      s1_im    <= imag_part;
      s1_shamt <= shamt_next;
      s1_four  <= four_quadrant;
      s1_zero  <= (real_part == '0) && (imag_part == '0);
    end
  end

  // stage 2: shift, divide by four, mirror
  logic signed [15:0]          sh_re;
  logic signed [15:0]          sh_im;
  logic signed [cna_pkg::XW-1:0] ext_re;
  logic signed [cna_pkg::XW-1:0] ext_im;
  cna_pkg::cna_vec_t           s2_next;

  assign sh_re  = s1_re << s1_shamt;
  assign sh_im  = s1_im << s1_shamt;
  assign ext_re = {{(cna_pkg::XW-14){sh_re[15]}}, sh_re[15:2]};
  assign ext_im = {{(cna_pkg::XW-14){sh_im[15]}}, sh_im[15:2]};

  always_comb begin
    s2_next.x    = sh_re[15] ? -ext_re : ext_re;
    s2_next.y    = ext_im;
    s2_next.acc  = '0;
    s2_next.neg  = sh_re[15];
    s2_next.four = s1_four;
    s2_next.zero = s1_zero;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready) begin
      out_data <= s2_next;
    end
  end

endmodule

// File: hdl/cna_cordic_stage.sv
// One CORDIC vectoring iteration with its own pipeline register.
module cna_cordic_stage #(
  parameter int IDX = 0
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  cna_pkg::cna_vec_t in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output cna_pkg::cna_vec_t out_data
);

  logic signed [cna_pkg::XW-1:0] x;
  logic signed [cna_pkg::XW-1:0] y;
  logic signed [cna_pkg::AW-1:0] acc;
  logic signed [cna_pkg::XW-1:0] xs;
  logic signed [cna_pkg::XW-1:0] ys;
  logic signed [cna_pkg::AW-1:0] step;
  cna_pkg::cna_vec_t             data_next;

  assign x    = in_data.x;
  assign y    = in_data.y;
  assign acc  = in_data.acc;
  assign xs   = x >>> IDX;
  assign ys   = y >>> IDX;
  assign step = {1'b0, cna_pkg::ATAN_STEP[IDX]};

  // y >= 0 rotates clockwise
  always_comb begin
    data_next = in_data;
    if (!y[cna_pkg::XW-1]) begin
      data_next.x   = x + ys;
      data_next.y   = y - xs;
      data_next.acc = acc + step;
    end else begin
      data_next.x   = x - ys;
      data_next.y   = y + xs;
      data_next.acc = acc - step;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      out_data <= data_next;
    end
  end

endmodule

// File: hdl/cordic_atan_normalized_core.sv
// Top level: normalized CORDIC arctangent pipeline.
//
//   channel | dir | handshake      | payload
//   --------+-----+----------------+----------------------------------------------
//   din     | in  | valid / ready  | real_part[15:0], imag_part[15:0], four_quadrant
//   dout    | out | valid / ready  | angle[15:0]
//
// One item per cycle sustained while dout is ready; CORDIC_STEPS + 3 register stages (two
// normalization, one per CORDIC step, output).
// Every stage has its own valid bit and advances when empty or when the next stage
// moves, so bubbles close up and items keep entering while a result waits.
// Reset (rst, synchronous) clears only the valid bits; data registers are not reset.
// A stall on dout holds every item in place; nothing is dropped or repeated.
module cordic_atan_normalized_core #(
  parameter int CORDIC_STEPS = 14   // 8..14
) (
  input  logic      clk,
  input  logic      rst,
  cna_in_if.sink    din,
  cna_out_if.source dout
);

  // stage index 0 is the normalizer output, k+1 the output of CORDIC step k
  logic              vld [0:CORDIC_STEPS];
  logic              rdy [0:CORDIC_STEPS];
  cna_pkg::cna_vec_t dat [0:CORDIC_STEPS];

  cna_norm u_norm (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (din.valid),
    .in_ready      (din.ready),
    .real_part     (din.real_part),
    .imag_part     (din.imag_part),
    .four_quadrant (din.four_quadrant),
    .out_valid     (vld[0]),
    .out_ready     (rdy[0]),
    .out_data      (dat[0])
  );

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_step
    cna_cordic_stage #(.IDX(k)) u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (vld[k]),
      .in_ready  (rdy[k]),
      .in_data   (dat[k]),
      .out_valid (vld[k+1]),
      .out_ready (rdy[k+1]),
      .out_data  (dat[k+1])
    );
  end

  // final combine: a zero vector gives a zero angle; the right half plane passes the sum;
  // the left half plane negates it, or subtracts it from a half turn in four-quadrant mode
  cna_pkg::cna_vec_t last;
  logic [15:0]       acc16;
  logic [15:0]       angle_next;
  logic              out_v;
  logic [15:0]       angle_q;

  assign last  = dat[CORDIC_STEPS];
  assign acc16 = last.acc[15:0];

  always_comb begin
    priority if (last.zero) begin
      angle_next = cna_pkg::ZERO_ANGLE;
    end else if (!last.neg) begin
      angle_next = acc16;
    end else if (last.four) begin
      angle_next = cna_pkg::HALF_TURN - acc16;
    end else begin
      angle_next = cna_pkg::ZERO_ANGLE - acc16;
    end
  end

  assign rdy[CORDIC_STEPS] = !out_v || dout.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (rdy[CORDIC_STEPS]) begin
      out_v <= vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[CORDIC_STEPS]) begin
      angle_q <= angle_next;
    end
  end

  assign dout.valid = out_v;
  assign dout.angle = angle_q;

endmodule

// File: hdl/cna_checker.sv
// Checker: port-level assertions for the CORDIC core, bound to the top level.
module cna_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] angle
);

  // a held result stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(angle))
    else $error("result changed while stalled");

  // a draining output frees every stage, so the input side must be open
  a_ready_chain: assert property (@(posedge clk) disable iff (rst)
    out_ready |-> in_ready)
    else $error("input blocked while output drains");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind cordic_atan_normalized_core cna_checker u_cna_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (din.ready),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .angle     (dout.angle)
);

// File: sim/tb_cordic_atan_normalized_core.sv
// Testbench: self-checking random and directed test of the normalized CORDIC arctangent core.
`timescale 1ns / 1ps

module tb_cordic_atan_normalized_core;

  localparam int STEPS = 14;            // CORDIC iterations in the core under test
  localparam int LATENCY = STEPS + 3;   // input to output, no output stall
  localparam int HOLD_CYCLES = 150;     // long output back-pressure stretch
  localparam int WATCHDOG_LIMIT = 2000; // cycles without any item moving
  localparam int RESET_CYCLES = 7;
  localparam int MAX_REPORTS = 10;

  // Scoreboard: predicts the angle of every accepted item and compares it
  // with the results in arrival order.
  class angle_scoreboard;
    logic signed [15:0] angle_q[$];
    int mismatches;
    int steps;

    function new(int n);
      steps = n;
      mismatches = 0;
    endfunction

    // Vectoring-mode rotation sum: drives the imaginary part toward zero.
    // A residual imaginary of zero counts as non-negative (clockwise step).
    function automatic int cordic_sum(int re, int im);
      int step_angle [0:13] = '{
        'h2000, 'h12e4, 'h09fb, 'h0511, 'h028b, 'h0146, 'h00a3,
        'h0051, 'h0029, 'h0014, 'h000a, 'h0005, 'h0003, 'h0001
      };
      int sum;
      int re_prev;
      sum = 0;
      for (int i = 0; i < steps && i < 14; i++) begin
        re_prev = re;
        if (im >= 0) begin
          re += im >>> i;
          im -= re_prev >>> i;
          sum += step_angle[i];
        end else begin
          re -= im >>> i;
          im += re_prev >>> i;
          sum -= step_angle[i];
        end
      end
      return sum;
    endfunction

    function automatic logic signed [15:0] expected_angle(logic signed [15:0] re_in,
                                                          logic signed [15:0] im_in,
                                                          logic four);
      int re;
      int im;
      int res;
      if (re_in == 0 && im_in == 0) return cna_pkg::ZERO_ANGLE;
      re = re_in;
      im = im_in;
      // shared left shift until either part uses its top two bits
      while (re[15] == re[14] && im[15] == im[14]) begin
        re = re * 2;
        im = im * 2;
      end
      re = re >>> 2;
      im = im >>> 2;
      if (re >= 0) begin
        res = cordic_sum(re, im);
      end else begin
        // left half plane: mirror, then negate or fold around a half turn
        res = (four ? int'(cna_pkg::HALF_TURN) : 0) - cordic_sum(-re, im);
      end
      return res[15:0];
    endfunction

    function void note_input(logic signed [15:0] re, logic signed [15:0] im, logic four);
      angle_q.push_back(expected_angle(re, im, four));
    endfunction

    function void check_result(logic signed [15:0] got);
      logic signed [15:0] want;
      if (angle_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: angle %0d arrived with no item outstanding", $time, got);
        return;
      end
      want = angle_q.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: angle mismatch, expected %0d (0x%h), got %0d (0x%h)",
                   $time, want, want, got, got);
      end
    endfunction

    function int pending();
      return angle_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  cna_in_if  in_ch();
  cna_out_if out_ch();

  cordic_atan_normalized_core #(
    .CORDIC_STEPS(STEPS)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .din (in_ch),
    .dout(out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  angle_scoreboard sb = new(STEPS);

  // Idle rates in percent; changed by the main sequence between phases.
  int src_idle_pct = 20;
  int snk_stall_pct = 87;
  // Set by the main sequence to start one long output hold-off.
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  // Output side: random ready, plus one long hold-off on request. The hold is
  // counted here so the sender keeps offering items meanwhile.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // Monitor: both channels sampled at the edge (pre-update values), plus the
  // watchdog on cycles in which no item moves on either channel.
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      sb.note_input(in_ch.real_part, in_ch.imag_part, in_ch.four_quadrant);
    if (!rst && out_ch.valid && out_ch.ready)
      sb.check_result(out_ch.angle);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Offer one item after a random idle gap; returns at the edge that takes it.
  task automatic send_item(input logic signed [15:0] re, input logic signed [15:0] im,
                           input logic four);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.real_part <= re;
    in_ch.imag_part <= im;
    in_ch.four_quadrant <= four;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Corners and the named cases: zero vector, both half planes in both modes,
  // zero imaginary (rotation on a zero residual), full-scale and tiny values.
  task automatic send_directed();
    send_item(16'sd0, 16'sd0, 1'b0);
    send_item(16'sd0, 16'sd0, 1'b1);
    send_item(16'sh7fff, 16'sh7fff, 1'b0);
    send_item(16'sh8000, 16'sh8000, 1'b0);
    send_item(16'sh8000, 16'sh8000, 1'b1);
    send_item(16'sh7fff, 16'sh8000, 1'b1);
    send_item(16'sh8000, 16'sh7fff, 1'b0);
    send_item(16'sh8000, 16'sh7fff, 1'b1);
    send_item(16'sh8000, 16'sd0, 1'b0);
    send_item(16'sh8000, 16'sd0, 1'b1);
    send_item(16'sd0, 16'sh8000, 1'b0);
    send_item(16'sd0, 16'sh7fff, 1'b1);
    send_item(16'sd1, 16'sd0, 1'b0);
    send_item(-16'sd1, 16'sd0, 1'b0);
    send_item(-16'sd1, 16'sd0, 1'b1);
    send_item(16'sd0, 16'sd1, 1'b0);
    send_item(16'sd0, -16'sd1, 1'b1);
    send_item(-16'sd1, -16'sd1, 1'b0);
    send_item(-16'sd1, -16'sd1, 1'b1);
    send_item(16'sd16384, -16'sd16384, 1'b0);
    send_item(-16'sd16383, 16'sd8191, 1'b1);
    send_item(16'sd100, 16'sd0, 1'b1);
    send_item(-16'sd5, 16'sd3, 1'b0);
    send_item(16'sd3, -16'sd5, 1'b1);
  endtask

  // Random items: mostly full range, some scaled down so the normalizer has
  // to shift far, some on an axis, some at full-scale corners.
  task automatic send_random(input int count);
    int sel;
    logic signed [15:0] re;
    logic signed [15:0] im;
    repeat (count) begin
      sel = $urandom_range(9);
      re = 16'($urandom);
      im = 16'($urandom);
      case (sel)
        5, 6: begin
          re = re >>> $urandom_range(15);
          im = im >>> $urandom_range(15);
        end
        7: begin
          if ($urandom_range(1)) re = '0;
          else im = '0;
        end
        8: begin
          re = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
          if ($urandom_range(1)) im = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        end
        default: ;
      endcase
      send_item(re, im, 1'($urandom_range(1)));
    end
  endtask

  // Hold the input idle until every outstanding angle has come back.
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.real_part = '0;
    in_ch.imag_part = '0;
    in_ch.four_quadrant = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // phase 1: sender mostly busy, receiver mostly stalled
    src_idle_pct = 20;
    snk_stall_pct = 87;
    send_directed();
    send_random(310);

    // phase 2: roles swapped
    src_idle_pct = 87;
    snk_stall_pct = 20;
    send_random(310);

    // phase 3: full rate; one long output hold so the pipe fills and
    // back-pressures the input, then a full drain before the rest
    src_idle_pct = 0;
    snk_stall_pct = 0;
    hold_req = 1'b1;
    send_random(80);
    drain();
    send_random(250);

    drain();
    repeat (LATENCY + 8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule

// File: files.f
hdl/cna_pkg.sv
hdl/cna_if.sv
hdl/cna_norm.sv
hdl/cna_cordic_stage.sv
hdl/cordic_atan_normalized_core.sv
hdl/cna_checker.sv
sim/tb_cordic_atan_normalized_core.sv
